// ===== rtl/gbfs_pkg.sv =====
// ----------------------------------------------------------------------------
// gbfs_pkg: shared types and constants
// Sequencer states for the grid walk unit.
// ----------------------------------------------------------------------------
package gbfs_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_SEED,
    ST_POP,
    ST_POPWAIT,
    ST_NBR,
    ST_NBRWAIT,
    ST_NBRCHK,
    ST_DONE
  } walk_state_t;

  localparam int unsigned BRANCH_LIMIT = 2;
  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_DOWN  = 2'd1;
  localparam logic [1:0] DIR_LEFT  = 2'd2;
  localparam logic [1:0] DIR_RIGHT = 2'd3;
  localparam logic CFG_ROWS = 1'b0;
  localparam logic CFG_COLS = 1'b1;

endpackage

// ===== rtl/grid_bfs_reachability_unit.sv =====
// ----------------------------------------------------------------------------
// grid_bfs_reachability_unit: breadth-first reachability on a loaded grid
// Loads open/blocked cells, then answers target or branch queries by a
// four-neighbour walk through memory-held visited map and cell queue.
// ----------------------------------------------------------------------------
//  channel | direction | handshake         | payload
//  in_     | input     | in_valid/in_ready | mode, cell, start, target, kind
//  out_    | output    | out_valid/ready   | answer
//  cfg_    | input     | cfg_we            | cfg_index, cfg_wdata (7 bits)
//
// A load is written into the open map when accepted. A query whose start lies in
// the grid first clears the visited map, one entry a cycle, then pops each queued
// cell and checks its neighbours in turn, plus seed, last pop and done.
// Reset (synchronous, rst_n low) empties the queue and sets 64x64 geometry.
// out_valid holds with its answer until taken; loads are still accepted while
// it waits, a query item waits at the input until the answer is taken.
module grid_bfs_reachability_unit #(
  parameter int unsigned MAX_ROWS = 64,
  parameter int unsigned MAX_COLS = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_mode,
  input  logic [5:0] in_cell_row,
  input  logic [5:0] in_cell_col,
  input  logic       in_cell_blocked,
  input  logic [5:0] in_start_row,
  input  logic [5:0] in_start_col,
  input  logic [5:0] in_target_row,
  input  logic [5:0] in_target_col,
  input  logic       in_search_kind,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_answer,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [6:0] cfg_wdata
);
  localparam int unsigned RW    = $clog2(MAX_ROWS);
  localparam int unsigned CW    = $clog2(MAX_COLS);
  localparam int unsigned AW    = RW + CW;
  localparam int unsigned CELLS = 1 << AW;
  // coordinates carried with two spare bits, never narrower than the 6-bit
  // fields, so -1 / out-of-range / target compare cleanly
  localparam int unsigned PW    =
    ((RW > CW) ? ((RW > 6) ? RW : 6) : ((CW > 6) ? CW : 6)) + 2;

  gbfs_pkg::walk_state_t state_r, state_nxt;

  logic [6:0] rows_cfg_r, cols_cfg_r;
  logic [RW:0] rows_r;   // clamped rows in use
  logic [CW:0] cols_r;
  logic [5:0] tr_r, tc_r;
  logic       seek_r;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [AW:0]   head_r, head_nxt, tail_r, tail_nxt;
  logic [RW-1:0] cr_r, cr_nxt;
  logic [CW-1:0] cc_r, cc_nxt;
  logic [1:0]    dir_r, dir_nxt;
  logic [2:0]    cnt_r, cnt_nxt;
  logic          ans_r, ans_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [AW-1:0] nidx_r, nidx_nxt;

  // memory ports
  logic          om_we, vm_we, vm_wd, fq_we;
  logic [AW-1:0] om_waddr, vm_addr, fq_waddr, fq_wdata, fq_raddr, om_raddr;
  logic          om_rd, vm_rd;
  logic [AW-1:0] fq_rd;

  gbfs_bitmem #(.DEPTH(CELLS), .AW(AW)) u_open (
    .clk(clk), .we(om_we), .waddr(om_waddr), .wdata(~in_cell_blocked),
    .raddr(om_raddr), .rdata(om_rd));
  gbfs_bitmem #(.DEPTH(CELLS), .AW(AW)) u_visit (
    .clk(clk), .we(vm_we), .waddr(vm_addr), .wdata(vm_wd),
    .raddr(vm_addr), .rdata(vm_rd));
  gbfs_fifo_mem #(.DEPTH(CELLS), .AW(AW)) u_queue (
    .clk(clk), .we(fq_we), .waddr(fq_waddr), .wdata(fq_wdata),
    .raddr(fq_raddr), .rdata(fq_rd));

  // clamp geometry into 1..MAX
  logic [RW:0] rows_cl;
  logic [CW:0] cols_cl;
  always_comb begin
    if (rows_cfg_r == 7'd0) rows_cl = (RW+1)'(1);
    else if ({25'd0, rows_cfg_r} > MAX_ROWS) rows_cl = (RW+1)'(MAX_ROWS);
    else rows_cl = (RW+1)'(rows_cfg_r);
    if (cols_cfg_r == 7'd0) cols_cl = (CW+1)'(1);
    else if ({25'd0, cols_cfg_r} > MAX_COLS) cols_cl = (CW+1)'(MAX_COLS);
    else cols_cl = (CW+1)'(cols_cfg_r);
  end

  logic accept;
  assign in_ready = (state_r == gbfs_pkg::ST_IDLE) &&
                    (!in_mode || !out_valid_r);
  assign accept   = in_valid && in_ready;

  // neighbour coordinates in signed PW-bit space
  logic signed [PW-1:0] nr, nc;
  logic nb_target, nb_ingrid;
  always_comb begin
    nr = signed'(PW'(cr_r));
    nc = signed'(PW'(cc_r));
    case (dir_r)
      gbfs_pkg::DIR_UP:    nr = nr - PW'(1);
      gbfs_pkg::DIR_DOWN:  nr = nr + PW'(1);
      gbfs_pkg::DIR_LEFT:  nc = nc - PW'(1);
      gbfs_pkg::DIR_RIGHT: nc = nc + PW'(1);
      default: ;
    endcase
    nb_target = (nr == signed'(PW'(tr_r))) && (nc == signed'(PW'(tc_r)));
    nb_ingrid = (nr >= 0) && (nc >= 0) && (nr < signed'(PW'(rows_r))) &&
                (nc < signed'(PW'(cols_r)));
  end

  logic start_ok;
  assign start_ok = ({26'd0, in_start_row} < 32'(rows_cl)) &&
                    ({26'd0, in_start_col} < 32'(cols_cl));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gbfs_pkg::ST_IDLE:
        if (accept && in_mode) begin
          state_nxt = start_ok ? gbfs_pkg::ST_CLEAR : gbfs_pkg::ST_DONE;
        end
      gbfs_pkg::ST_CLEAR:
        if (clr_r == AW'(CELLS - 1)) state_nxt = gbfs_pkg::ST_SEED;
      gbfs_pkg::ST_SEED:    state_nxt = gbfs_pkg::ST_POP;
      gbfs_pkg::ST_POP:
        state_nxt = (head_r < tail_r) ? gbfs_pkg::ST_POPWAIT : gbfs_pkg::ST_DONE;
      gbfs_pkg::ST_POPWAIT: state_nxt = gbfs_pkg::ST_NBR;
      gbfs_pkg::ST_NBR:
        if (seek_r && nb_target) state_nxt = gbfs_pkg::ST_DONE;
        else if (nb_ingrid) state_nxt = gbfs_pkg::ST_NBRWAIT;
        else if (dir_r == gbfs_pkg::DIR_RIGHT) begin
          state_nxt = (!seek_r && cnt_r > 3'(gbfs_pkg::BRANCH_LIMIT)) ?
                      gbfs_pkg::ST_DONE : gbfs_pkg::ST_POP;
        end
      gbfs_pkg::ST_NBRWAIT: state_nxt = gbfs_pkg::ST_NBRCHK;
      gbfs_pkg::ST_NBRCHK:
        if (dir_r == gbfs_pkg::DIR_RIGHT) begin
          state_nxt = (!seek_r && cnt_nxt > 3'(gbfs_pkg::BRANCH_LIMIT)) ?
                      gbfs_pkg::ST_DONE : gbfs_pkg::ST_POP;
        end else begin
          state_nxt = gbfs_pkg::ST_NBR;
        end
      gbfs_pkg::ST_DONE:    state_nxt = gbfs_pkg::ST_IDLE;
      default:              state_nxt = gbfs_pkg::ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    clr_nxt = clr_r; head_nxt = head_r; tail_nxt = tail_r;
    cr_nxt = cr_r; cc_nxt = cc_r; dir_nxt = dir_r; cnt_nxt = cnt_r;
    ans_nxt = ans_r; nidx_nxt = nidx_r;
    out_valid_nxt = out_valid_r && !out_ready;
    om_we = 1'b0; om_waddr = {RW'(in_cell_row), CW'(in_cell_col)};
    om_raddr = nidx_r;
    vm_we = 1'b0; vm_wd = 1'b0; vm_addr = clr_r;
    fq_we = 1'b0; fq_waddr = tail_r[AW-1:0]; fq_wdata = nidx_r;
    fq_raddr = head_r[AW-1:0];
    case (state_r)
      gbfs_pkg::ST_IDLE: begin
        if (accept && !in_mode) begin
          // loads outside storage are dropped
          om_we = ({26'd0, in_cell_row} < MAX_ROWS) &&
                  ({26'd0, in_cell_col} < MAX_COLS);
        end
        if (accept && in_mode) begin
          clr_nxt = '0; head_nxt = '0; tail_nxt = '0; ans_nxt = 1'b0;
          cr_nxt = RW'(in_start_row); cc_nxt = CW'(in_start_col);
        end
      end
      gbfs_pkg::ST_CLEAR: begin
        vm_we = 1'b1; vm_wd = 1'b0; vm_addr = clr_r;
        clr_nxt = clr_r + AW'(1);
      end
      gbfs_pkg::ST_SEED: begin
        vm_we = 1'b1; vm_wd = 1'b1; vm_addr = {cr_r, cc_r};
        fq_we = 1'b1; fq_waddr = '0; fq_wdata = {cr_r, cc_r};
        tail_nxt = (AW+1)'(1);
      end
      gbfs_pkg::ST_POP: begin
        fq_raddr = head_r[AW-1:0];
        if (head_r < tail_r) head_nxt = head_r + (AW+1)'(1);
      end
      gbfs_pkg::ST_POPWAIT: begin
        cr_nxt = fq_rd[AW-1:CW]; cc_nxt = fq_rd[CW-1:0];
        dir_nxt = gbfs_pkg::DIR_UP; cnt_nxt = '0;
      end
      gbfs_pkg::ST_NBR: begin
        nidx_nxt = {nr[RW-1:0], nc[CW-1:0]};
        om_raddr = {nr[RW-1:0], nc[CW-1:0]};
        vm_addr  = {nr[RW-1:0], nc[CW-1:0]};
        if (seek_r && nb_target) ans_nxt = 1'b1;
        else if (!nb_ingrid) begin
          if (dir_r == gbfs_pkg::DIR_RIGHT) begin
            if (!seek_r && cnt_r > 3'(gbfs_pkg::BRANCH_LIMIT)) ans_nxt = 1'b1;
          end else dir_nxt = dir_r + 2'd1;
        end
      end
      gbfs_pkg::ST_NBRWAIT: begin
        vm_addr = nidx_r;
      end
      gbfs_pkg::ST_NBRCHK: begin
        vm_addr = nidx_r;
        if (om_rd) begin
          cnt_nxt = cnt_r + 3'd1;
          if (!vm_rd && tail_r < (AW+1)'(CELLS)) begin
            vm_we = 1'b1; vm_wd = 1'b1;
            fq_we = 1'b1; fq_waddr = tail_r[AW-1:0]; fq_wdata = nidx_r;
            tail_nxt = tail_r + (AW+1)'(1);
          end
        end
        if (dir_r == gbfs_pkg::DIR_RIGHT) begin
          if (!seek_r && cnt_nxt > 3'(gbfs_pkg::BRANCH_LIMIT)) ans_nxt = 1'b1;
        end else dir_nxt = dir_r + 2'd1;
      end
      gbfs_pkg::ST_DONE: out_valid_nxt = 1'b1;
      default: ;
    endcase
  end

  assign out_valid  = out_valid_r;
  assign out_answer = ans_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gbfs_pkg::ST_IDLE;
      rows_cfg_r <= 7'd64; cols_cfg_r <= 7'd64;
      head_r <= '0; tail_r <= '0; clr_r <= '0;
      out_valid_r <= 1'b0;
      dir_r <= gbfs_pkg::DIR_UP; cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we && cfg_index == gbfs_pkg::CFG_ROWS) rows_cfg_r <= cfg_wdata;
      if (cfg_we && cfg_index == gbfs_pkg::CFG_COLS) cols_cfg_r <= cfg_wdata;
      head_r <= head_nxt; tail_r <= tail_nxt; clr_r <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      dir_r <= dir_nxt; cnt_r <= cnt_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cr_r <= cr_nxt; cc_r <= cc_nxt; nidx_r <= nidx_nxt;
    if (state_r != gbfs_pkg::ST_IDLE || out_valid_r) ans_r <= ans_nxt;
    else ans_r <= ans_nxt;
    if (accept && in_mode) begin
      tr_r <= in_target_row; tc_r <= in_target_col; seek_r <= in_search_kind;
      rows_r <= rows_cl; cols_r <= cols_cl;
    end
  end
endmodule

// ===== rtl/gbfs_bitmem.sv =====
// ----------------------------------------------------------------------------
// gbfs_bitmem: one-bit-wide synchronous memory
// One write port, one registered read port.
// ----------------------------------------------------------------------------
module gbfs_bitmem #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = 12
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic          wdata,
  input  logic [AW-1:0] raddr,
  output logic          rdata
);
  logic mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/gbfs_fifo_mem.sv =====
// ----------------------------------------------------------------------------
// gbfs_fifo_mem: cell queue storage
// Holds cell indices of the walk; registered read.
// ----------------------------------------------------------------------------
module gbfs_fifo_mem #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = 12
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [AW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [AW-1:0] rdata
);
  logic [AW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench for grid_bfs_reachability_unit
// Loads small walled pockets and grids of open and blocked cells, runs target
// and branch queries under several geometries, and compares each answer with
// an in-bench walk model.
// ----------------------------------------------------------------------------
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NROW = 64;
  localparam int unsigned NCOL = 64;
  localparam int unsigned NCELL = NROW * NCOL;
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_QUERY = 1'b1;
  localparam logic KIND_BRANCH = 1'b0;
  localparam logic KIND_TARGET = 1'b1;
  // loads leave no result; this covers one still in flight before a cfg write
  localparam int unsigned SETTLE_CYCLES = 16;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_mode = MODE_LOAD;
  logic [5:0] in_cell_row = '0;
  logic [5:0] in_cell_col = '0;
  logic in_cell_blocked = 1'b0;
  logic [5:0] in_start_row = '0;
  logic [5:0] in_start_col = '0;
  logic [5:0] in_target_row = '0;
  logic [5:0] in_target_col = '0;
  logic in_search_kind = KIND_BRANCH;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_answer;
  logic cfg_we = 1'b0;
  logic cfg_index = gbfs_pkg::CFG_ROWS;
  logic [6:0] cfg_wdata = '0;

  grid_bfs_reachability_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_mode(in_mode),
    .in_cell_row(in_cell_row), .in_cell_col(in_cell_col),
    .in_cell_blocked(in_cell_blocked),
    .in_start_row(in_start_row), .in_start_col(in_start_col),
    .in_target_row(in_target_row), .in_target_col(in_target_col),
    .in_search_kind(in_search_kind),
    .out_valid(out_valid), .out_ready(out_ready), .out_answer(out_answer),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #10 clk = ~clk;

  // Mirror of the block: cell map, which cells were loaded, geometry in use.
  bit cell_open [NCELL];
  bit cell_loaded [NCELL];
  bit seen [NCELL];
  int unsigned rows_used = 64;
  int unsigned cols_used = 64;

  bit answers_due [$];
  int unsigned error_count = 0;
  int unsigned answers_checked = 0;
  int unsigned loads_sent = 0;
  int unsigned queries_sent = 0;
  int unsigned ones_seen = 0;
  bit calm = 1'b0;           // no random idling on either side while set
  int unsigned hold_cycles = 0;

  task automatic report_mismatch(input string what);
    error_count++;
    $display("mismatch at %0t: %s", $realtime, what);
  endtask

  // Breadth-first walk as the block does it. touches_unloaded flags a walk
  // that would read a cell never loaded; such queries are never sent.
  function automatic bit walk_answer(input int sr, input int sc, input int tr,
                                     input int tc, input bit seek_target,
                                     output bit touches_unloaded);
    int q [$];
    int cur, r, c, nr, nc, idx, open_nbrs;
    touches_unloaded = 1'b0;
    if (sr >= rows_used || sc >= cols_used) return 1'b0;
    foreach (seen[i]) seen[i] = 1'b0;
    q.push_back(sr * NCOL + sc);
    seen[sr * NCOL + sc] = 1'b1;
    while (q.size() > 0) begin
      cur = q.pop_front();
      r = cur / NCOL;
      c = cur % NCOL;
      open_nbrs = 0;
      for (int d = 0; d < 4; d++) begin
        nr = r + ((d == gbfs_pkg::DIR_UP) ? -1 : (d == gbfs_pkg::DIR_DOWN) ? 1 : 0);
        nc = c + ((d == gbfs_pkg::DIR_LEFT) ? -1 : (d == gbfs_pkg::DIR_RIGHT) ? 1 : 0);
        // target match comes before the bounds and wall checks
        if (seek_target && nr == tr && nc == tc) return 1'b1;
        if (nr >= 0 && nr < rows_used && nc >= 0 && nc < cols_used) begin
          idx = nr * NCOL + nc;
          if (!cell_loaded[idx]) touches_unloaded = 1'b1;
          if (cell_open[idx]) begin
            open_nbrs++;
            if (!seen[idx]) begin
              seen[idx] = 1'b1;
              q.push_back(idx);
            end
          end
        end
      end
      if (!seek_target && open_nbrs > gbfs_pkg::BRANCH_LIMIT) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Result checker: one expected answer per query, oldest first.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (answers_due.size() == 0) begin
        report_mismatch("answer with no query outstanding");
      end else begin
        bit want;
        want = answers_due.pop_front();
        answers_checked++;
        if (out_answer) ones_seen++;
        if (out_answer !== want)
          report_mismatch($sformatf("answer %b, expected %b", out_answer, want));
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off when asked for.
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= 8);
    end
  end

  // Sends one item; valid is left high so back-to-back items need no toggle.
  task automatic send_item(input logic mode, input logic [5:0] cr, input logic [5:0] cc,
                           input logic cb, input logic [5:0] sr, input logic [5:0] sc,
                           input logic [5:0] tr, input logic [5:0] tc, input logic kind);
    bit want, bad;
    if (!calm && $urandom_range(99) < 8) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= mode;
    in_cell_row <= cr;
    in_cell_col <= cc;
    in_cell_blocked <= cb;
    in_start_row <= sr;
    in_start_col <= sc;
    in_target_row <= tr;
    in_target_col <= tc;
    in_search_kind <= kind;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (mode == MODE_LOAD) begin
      cell_open[cr * NCOL + cc] = !cb;
      cell_loaded[cr * NCOL + cc] = 1'b1;
      loads_sent++;
    end else begin
      want = walk_answer(sr, sc, tr, tc, kind, bad);
      answers_due.push_back(want);
      queries_sent++;
    end
  endtask

  task automatic load_cell(input int r, input int c, input bit blocked);
    send_item(MODE_LOAD, 6'(r), 6'(c), blocked, 6'($urandom), 6'($urandom),
              6'($urandom), 6'($urandom), 1'($urandom));
  endtask

  task automatic query(input int sr, input int sc, input int tr, input int tc,
                       input bit kind);
    send_item(MODE_QUERY, 6'($urandom), 6'($urandom), 1'($urandom), 6'(sr), 6'(sc),
              6'(tr), 6'(tc), kind);
  endtask

  // Loads every cell of the rows x cols corner with the given wall rate.
  task automatic load_region(input int rows, input int cols, input int wall_pct);
    for (int r = 0; r < rows; r++)
      for (int c = 0; c < cols; c++)
        load_cell(r, c, $urandom_range(99) < wall_pct);
  endtask

  // Writes both geometry registers once the block has gone quiet.
  task automatic set_geometry(input logic [6:0] rows, input logic [6:0] cols);
    in_valid <= 1'b0;
    @(posedge clk);
    while (answers_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= gbfs_pkg::CFG_ROWS;
    cfg_wdata <= rows;
    @(posedge clk);
    cfg_index <= gbfs_pkg::CFG_COLS;
    cfg_wdata <= cols;
    @(posedge clk);
    cfg_we <= 1'b0;
    rows_used = (rows < 1) ? 1 : (rows > NROW) ? NROW : rows;
    cols_used = (cols < 1) ? 1 : (cols > NCOL) ? NCOL : cols;
  endtask

  // Random query whose walk stays on loaded cells; start may fall off grid.
  task automatic random_query();
    int sr, sc, tr, tc;
    bit kind, bad, want;
    for (int tries = 0; tries < 50; tries++) begin
      sr = ($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(rows_used);
      sc = ($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(cols_used);
      tr = ($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(rows_used);
      tc = ($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(cols_used);
      sr = (sr > 63) ? 63 : sr;
      sc = (sc > 63) ? 63 : sc;
      tr = (tr > 63) ? 63 : tr;
      tc = (tc > 63) ? 63 : tc;
      kind = 1'($urandom);
      want = walk_answer(sr, sc, tr, tc, kind, bad);
      if (!bad) break;
    end
    if (bad) begin
      sr = 63;  // off grid whenever the grid is smaller
      sc = 63;
    end
    query(sr, sc, tr, tc, kind);
  endtask

  // Reset 64x64 geometry with walled pockets at corners and mid grid.
  task automatic test_full_grid();
    load_cell(0, 0, 1'b1);       // blocked start still walks
    load_cell(0, 1, 1'b1);
    load_cell(1, 0, 1'b1);
    load_cell(63, 63, 1'b0);
    load_cell(62, 63, 1'b0);
    load_cell(63, 62, 1'b1);
    load_cell(61, 63, 1'b1);
    load_cell(62, 62, 1'b1);
    load_cell(30, 32, 1'b0);     // plus shape around (31,32)
    load_cell(32, 32, 1'b0);
    load_cell(31, 31, 1'b0);
    load_cell(31, 33, 1'b0);
    query(0, 0, 63, 63, KIND_TARGET);
    query(63, 63, 0, 0, KIND_BRANCH);
    query(63, 63, 63, 62, KIND_TARGET);  // target next to start
    query(63, 63, 61, 63, KIND_TARGET);  // target next to a dequeued cell
    query(0, 0, 0, 0, KIND_TARGET);      // target equal to start only
    query(31, 32, 0, 0, KIND_BRANCH);    // start has four open neighbours
  endtask

  // Geometry extremes, saturation of zero and oversize registers.
  task automatic test_geometry_extremes();
    set_geometry(1, 1);
    load_cell(0, 0, 1'b0);
    query(0, 0, 0, 1, KIND_TARGET);   // target outside grid matches anyway
    query(0, 0, 5, 5, KIND_TARGET);
    query(0, 0, 0, 0, KIND_BRANCH);
    query(1, 0, 0, 1, KIND_TARGET);   // start outside grid
    set_geometry(0, 0);
    query(0, 0, 1, 0, KIND_TARGET);
    query(0, 1, 0, 0, KIND_TARGET);   // start outside grid
    set_geometry(127, 127);
    query(31, 32, 0, 0, KIND_BRANCH);
    set_geometry(1, 64);
    query(0, 0, 0, 1, KIND_TARGET);
    query(0, 0, 9, 9, KIND_BRANCH);
    set_geometry(64, 1);
    query(0, 0, 63, 0, KIND_TARGET);
    query(5, 1, 9, 9, KIND_BRANCH);   // start outside grid
    set_geometry(3, 3);
    load_region(3, 3, 0);
    query(1, 1, 9, 9, KIND_BRANCH);    // centre has four open neighbours
    query(0, 0, 9, 9, KIND_TARGET);    // exhausts the grid
  endtask

  // Several small random grids, each fully loaded, then random queries.
  // The last grid is 4x4 and stays loaded for the stall test.
  task automatic test_random_grids();
    int rows, cols;
    calm = 1'b1;  // no idling through the first grid
    for (int phase = 0; phase < 4; phase++) begin
      rows = (phase == 3) ? 4 : $urandom_range(4, 1);
      cols = (phase == 3) ? 4 : $urandom_range(4, 1);
      set_geometry(7'(rows), 7'(cols));
      load_region(rows, cols, $urandom_range(45, 10));
      repeat (5) begin
        if ($urandom_range(9) == 0)
          load_cell($urandom_range(rows - 1), $urandom_range(cols - 1), 1'($urandom));
        random_query();
      end
      calm = 1'b0;
    end
  endtask

  // Receiver holds off far longer than a query so the block backs up.
  task automatic test_output_stall();
    set_geometry(4, 4);
    hold_cycles = 20000;
    repeat (4) random_query();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_full_grid();
    test_geometry_extremes();
    test_random_grids();
    test_output_stall();
    in_valid <= 1'b0;
    @(posedge clk);
    while (answers_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("covered %0d cell loads and %0d queries, %0d answers checked (%0d ones)",
             loads_sent, queries_sent, answers_checked, ones_seen);
    $display("geometries 1x1 to 64x64 with saturation, both search kinds, output stall");
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #400ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
